@@ src/assert_macros.svh @@
// Assertion macros shared by the date validator RTL.
// Each macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every clock edge outside reset.
`define DSV_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that cons holds in the cycle after ante.
`define DSV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/dsv_pkg.sv @@
// Package for the date string validator: widths, character codes, parser
// constants and the month length table. No dependencies.
`default_nettype none

package dsv_pkg;

	localparam int CHAR_W  = 8;
	localparam int FIELD_W = 14;
	localparam int RUN_W   = 3;
	localparam int FS_W    = 2;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;
	localparam int MLEN_W  = 5;

	typedef logic [CHAR_W-1:0]  char_t;
	typedef logic [FIELD_W-1:0] field_t;
	typedef logic [RUN_W-1:0]   run_t;
	typedef logic [FS_W-1:0]    fs_t;

	localparam char_t CHAR_TERM  = 8'h00;
	localparam char_t CHAR_SLASH = 8'h2F;
	localparam char_t CHAR_ZERO  = 8'h30;
	localparam char_t CHAR_NINE  = 8'h39;

	localparam run_t RUN_NONE    = 3'd0;
	localparam run_t RUN_FIRST   = 3'd1;
	localparam run_t RUN_MAX     = 3'd4;
	localparam run_t RUN_DISCARD = 3'd5;

	localparam fs_t FS_FULL = 2'd3;

	localparam field_t YEAR_FLOOR_RST = 14'd1900;
	localparam field_t MONTH_LAST     = 14'd12;

	// Register index as decoded from paddr.
	localparam logic REG_YEAR_FLOOR = 1'b0;

	// Stage-one word handed from the input register to the parser.
	typedef struct packed {
		logic  valid;
		char_t code;
	} dsv_char_s1_t;

	// Days in a month, indexed by month 1..12, no leap years.
	function automatic logic [MLEN_W-1:0] month_len(input logic [3:0] month);
		logic [MLEN_W-1:0] len;
		case (month)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

@@ src/dsv_char_if.sv @@
// Character input channel of the date validator: valid, ready and one character.
// Depends on dsv_pkg.
`default_nettype none

interface dsv_char_if;
	logic             valid;
	logic             ready;
	dsv_pkg::char_t   char_code;

	modport source (output valid, output char_code, input ready);
	modport sink   (input valid, input char_code, output ready);
endinterface

`default_nettype wire

@@ src/dsv_date_if.sv @@
// Result channel of the date validator: valid, ready and the parsed date word.
// Depends on dsv_pkg.
`default_nettype none

interface dsv_date_if;
	logic             valid;
	logic             ready;
	logic             date_valid;
	dsv_pkg::field_t  day_field;
	dsv_pkg::field_t  month_field;
	dsv_pkg::field_t  year_field;

	modport source (output valid, output date_valid, output day_field,
		output month_field, output year_field, input ready);
	modport sink   (input valid, input date_valid, input day_field,
		input month_field, input year_field, output ready);
endinterface

`default_nettype wire

@@ src/dsv_apb_regs.sv @@
// APB register file of the date validator: holds the year floor.
// Depends on dsv_pkg.
`default_nettype none

module dsv_apb_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [dsv_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [dsv_pkg::DATA_W-1:0]  pwdata,
	output logic      [dsv_pkg::DATA_W-1:0]  prdata,
	output logic                             pready,
	output dsv_pkg::field_t                  year_floor
);
	import dsv_pkg::*;

	field_t year_floor_q;
	logic   wr_en;
	logic   sel_floor;

	assign pready    = 1'b1;
	assign sel_floor = (paddr[ADDR_W-1] == REG_YEAR_FLOOR);
	assign wr_en     = psel && penable && pwrite && pready && sel_floor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_floor_q <= YEAR_FLOOR_RST;
		end else if (wr_en) begin
			year_floor_q <= pwdata[FIELD_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_floor) begin
			prdata = DATA_W'(year_floor_q);
		end
	end

	assign year_floor = year_floor_q;

endmodule

`default_nettype wire

@@ src/dsv_parser.sv @@
// Parser and judge of the date validator: advances the field state by one
// character per cycle and loads the result register on a terminator, which
// waits for room there. Depends on dsv_pkg, dsv_date_if and assert_macros.svh.
`default_nettype none

module dsv_parser (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire dsv_pkg::dsv_char_s1_t char_s1,
	input  wire dsv_pkg::field_t      year_floor,
	output logic                      take,
	dsv_date_if.source                date_out
);
	import dsv_pkg::*;

	`include "assert_macros.svh"

	field_t acc_q [3];
	field_t acc_d [3];
	run_t   run_q, run_d;
	fs_t    fs_q, fs_d;
	logic   bad_q, bad_d;

	logic   is_term, is_digit, is_slash;
	logic   slot_free;
	logic [3:0] digit;
	fs_t    open_idx;
	field_t acc_sel;
	logic [FIELD_W+3:0] mac;
	logic   month_ok, year_ok, day_ok, verdict;

	assign is_term   = (char_s1.code == CHAR_TERM);
	assign is_digit  = (char_s1.code >= CHAR_ZERO) && (char_s1.code <= CHAR_NINE);
	assign is_slash  = (char_s1.code == CHAR_SLASH);
	assign digit     = 4'(char_s1.code - CHAR_ZERO);
	assign slot_free = !date_out.valid || date_out.ready;
	// A terminator waits until the result register can take its word.
	assign take      = char_s1.valid && (!is_term || slot_free);

	assign open_idx = fs_q - 2'd1;

	always_comb begin
		case (open_idx)
			2'd0:    acc_sel = acc_q[0];
			2'd1:    acc_sel = acc_q[1];
			2'd2:    acc_sel = acc_q[2];
			default: acc_sel = '0;
		endcase
	end

	// Times ten as two shifted copies, plus the new digit.
	assign mac = {1'b0, acc_sel, 3'b000} + {3'b000, acc_sel, 1'b0} + (FIELD_W+4)'(digit);

	always_comb begin
		run_d = run_q;
		fs_d  = fs_q;
		bad_d = bad_q;
		for (int i = 0; i < 3; i++) begin
			acc_d[i] = acc_q[i];
		end
		if (is_term) begin
			run_d = RUN_NONE;
			fs_d  = '0;
			bad_d = 1'b0;
			for (int i = 0; i < 3; i++) begin
				acc_d[i] = '0;
			end
		end else if (!bad_q) begin
			if (is_digit) begin
				if (run_q == RUN_DISCARD) begin
					run_d = run_q;
				end else if (run_q == RUN_NONE || run_q >= RUN_MAX) begin
					if (fs_q == FS_FULL) begin
						run_d = RUN_DISCARD;
					end else begin
						for (int i = 0; i < 3; i++) begin
							if (fs_q == FS_W'(i)) begin
								acc_d[i] = FIELD_W'(digit);
							end
						end
						fs_d  = fs_q + 2'd1;
						run_d = RUN_FIRST;
					end
				end else begin
					for (int i = 0; i < 3; i++) begin
						if (open_idx == FS_W'(i)) begin
							acc_d[i] = mac[FIELD_W-1:0];
						end
					end
					run_d = run_q + 3'd1;
				end
			end else if (is_slash) begin
				if (run_q != RUN_DISCARD) begin
					run_d = RUN_NONE;
				end
			end else begin
				bad_d = 1'b1;
			end
		end
	end

	always_comb begin
		month_ok = acc_q[1] inside {[14'd1:MONTH_LAST]};
		year_ok  = acc_q[2] > year_floor;
		day_ok   = (acc_q[0] != '0) &&
			(acc_q[0] <= FIELD_W'(month_len(acc_q[1][3:0])));
		verdict  = !bad_q && month_ok && year_ok && day_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= RUN_NONE;
			fs_q  <= '0;
			bad_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				acc_q[i] <= '0;
			end
		end else if (take) begin
			run_q <= run_d;
			fs_q  <= fs_d;
			bad_q <= bad_d;
			for (int i = 0; i < 3; i++) begin
				acc_q[i] <= acc_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			date_out.valid <= 1'b0;
		end else if (take && is_term) begin
			date_out.valid <= 1'b1;
		end else if (date_out.ready) begin
			date_out.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && is_term) begin
			date_out.date_valid  <= verdict;
			date_out.day_field   <= acc_q[0];
			date_out.month_field <= acc_q[1];
			date_out.year_field  <= acc_q[2];
		end
	end

	`DSV_ASSERT(a_discard_needs_full, (run_q != RUN_DISCARD) || (fs_q == FS_FULL),
		"digits dropped before three fields were started")
	`DSV_ASSERT_NEXT(a_term_clears, take && is_term,
		fs_q == '0 && run_q == RUN_NONE && !bad_q && date_out.valid,
		"terminator did not clear the state and post a result")
	`DSV_ASSERT_NEXT(a_bad_freezes, bad_q && take && !is_term,
		bad_q && $stable(acc_q[0]) && $stable(acc_q[1]) && $stable(acc_q[2]),
		"fields changed after a bad character")

endmodule

`default_nettype wire

@@ src/date_string_validator.sv @@
// A result word turns valid in the cycle after the parser takes its terminator.
// Throughput: one character per cycle; a terminator, and the input behind it, waits
// only while the result register holds a word that has not been taken.
// Reset (arst_n low, asynchronous): field state and valid flags clear at once,
// year_floor returns to 1900; no memory, so no clearing pass.
// Depends on dsv_pkg, dsv_char_if, dsv_date_if, dsv_apb_regs, dsv_parser.
`default_nettype none

module date_string_validator (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	dsv_char_if.sink                         char_in,
	dsv_date_if.source                       date_out,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [dsv_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [dsv_pkg::DATA_W-1:0]  pwdata,
	output logic      [dsv_pkg::DATA_W-1:0]  prdata,
	output logic                             pready
);
	import dsv_pkg::*;

	`include "assert_macros.svh"

	logic         valid_s1;
	char_t        code_s1;
	dsv_char_s1_t char_s1;
	logic         take;
	field_t       year_floor;

	// The input register refills whenever it is empty or its word moves on.
	assign char_in.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_in.ready) begin
			valid_s1 <= char_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_in.valid && char_in.ready) begin
			code_s1 <= char_in.char_code;
		end
	end

	assign char_s1.valid = valid_s1;
	assign char_s1.code  = code_s1;

	dsv_apb_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.year_floor (year_floor)
	);

	dsv_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_s1    (char_s1),
		.year_floor (year_floor),
		.take       (take),
		.date_out   (date_out)
	);

	`DSV_ASSERT_NEXT(a_s1_holds, valid_s1 && !take,
		valid_s1 && $stable(code_s1),
		"stalled character lost from the input register")

endmodule

`default_nettype wire

@@ tb/date_string_validator_tb.sv @@
// Testbench for date_string_validator: streams date texts one character per word,
// predicts each result word and checks it field by field, across several year floors.
// Depends on dsv_pkg, dsv_char_if, dsv_date_if and the date_string_validator RTL.
`default_nettype none

module date_string_validator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dsv_pkg::*;

	localparam int PHASE_ITEMS    = 270;
	localparam int SETTLE_CYCLES  = 6;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MONTH_DAYS[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
	localparam int DECADE[4] = '{1, 10, 100, 1000};
	// The only register sits at byte address zero.
	localparam logic [ADDR_W-1:0] ADDR_YEAR_FLOOR = {REG_YEAR_FLOOR, 2'b00};

	typedef struct packed {
		logic   ok;
		field_t day;
		field_t month;
		field_t year;
	} date_word_t;

	typedef struct {
		string      text;
		bit         typed;
		date_word_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	dsv_char_if char_bus ();
	dsv_date_if date_bus ();

	date_string_validator uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.char_in  (char_bus),
		.date_out (date_bus),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Parser state mirrored by the predictor.
	field_t     acc[3];
	fs_t        fields_begun;
	run_t       run_len;
	bit         bad_seen;
	field_t     floor_now = YEAR_FLOOR_RST;

	date_word_t dates_due[$];
	char_t      pending[$];
	field_t     floor_plan[6];
	int         mismatches = 0;
	int         quiet = 0;
	bit         tx_idle = 1'b1;
	bit         rx_idle = 1'b1;

	// Rows with a typed result assume the reset year floor of 1900.
	dir_row_t dir_rows[16] = '{
		'{"",              1'b1, '{1'b0, 14'd0,    14'd0,    14'd0}},
		'{"31/12/9999",    1'b1, '{1'b1, 14'd31,   14'd12,   14'd9999}},
		'{"1/1/1901",      1'b1, '{1'b1, 14'd1,    14'd1,    14'd1901}},
		'{"01/01/1900",    1'b1, '{1'b0, 14'd1,    14'd1,    14'd1900}},
		'{"28/2/2023",     1'b1, '{1'b1, 14'd28,   14'd2,    14'd2023}},
		'{"29/2/2023",     1'b1, '{1'b0, 14'd29,   14'd2,    14'd2023}},
		'{"31/4/2000",     1'b1, '{1'b0, 14'd31,   14'd4,    14'd2000}},
		'{"0/13/0",        1'b1, '{1'b0, 14'd0,    14'd13,   14'd0}},
		'{"7/3/2000z",     1'b1, '{1'b0, 14'd7,    14'd3,    14'd2000}},
		'{"12/x5/2000",    1'b1, '{1'b0, 14'd12,   14'd0,    14'd0}},
		'{"123456789",     1'b1, '{1'b0, 14'd1234, 14'd5678, 14'd9}},
		'{"1/2/3/4/5",     1'b0, '0},
		'{"15/6/20001234", 1'b0, '0},
		'{"//5//9:",       1'b0, '0},
		'{"9\377/\200/1.", 1'b0, '0},
		'{"31/1/9999/",    1'b0, '0}
	};

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Returns 1 and the predicted word when the character is a terminator.
	function automatic bit parse_char(input char_t c, output date_word_t word);
		int d;
		word = '0;
		if (c == CHAR_TERM) begin
			word.ok = !bad_seen && acc[1] >= 1 && acc[1] <= MONTH_LAST && acc[2] > floor_now
				&& acc[0] >= 1 && acc[0] <= MONTH_DAYS[acc[1] - 1];
			word.day = acc[0];
			word.month = acc[1];
			word.year = acc[2];
			acc = '{default: '0};
			fields_begun = '0;
			run_len = RUN_NONE;
			bad_seen = 1'b0;
			return 1'b1;
		end
		if (bad_seen)
			return 1'b0;
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			d = int'(c - CHAR_ZERO);
			if (run_len != RUN_DISCARD) begin
				if (run_len == RUN_NONE || run_len >= RUN_MAX) begin
					// A full run or a fresh run opens the next field, if one is left.
					if (fields_begun == FS_FULL) begin
						run_len = RUN_DISCARD;
					end else begin
						acc[fields_begun] = field_t'(d);
						fields_begun++;
						run_len = RUN_FIRST;
					end
				end else begin
					acc[fields_begun - 1] = field_t'(acc[fields_begun - 1] * 10 + d);
					run_len++;
				end
			end
		end else if (c == CHAR_SLASH) begin
			if (run_len != RUN_DISCARD)
				run_len = RUN_NONE;
		end else begin
			bad_seen = 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void put_num(input int v);
		int need;
		int ndig;
		need = (v >= 1000) ? 4 : (v >= 100) ? 3 : (v >= 10) ? 2 : 1;
		ndig = $urandom_range(0, 1) ? need : int'($urandom_range(need, 4));
		for (int i = ndig - 1; i >= 0; i--)
			pending.push_back(CHAR_ZERO + char_t'((v / DECADE[i]) % 10));
	endfunction

	function automatic void put_sep();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick >= 5)
			pending.push_back(CHAR_SLASH);
		if (pick >= 90)
			pending.push_back(CHAR_SLASH);
	endfunction

	function automatic void build_date_text();
		int kind;
		int month;
		int year;
		int pos;
		char_t junk;
		pending.delete();
		kind = $urandom_range(0, 99);
		if (kind < 12) begin
			repeat ($urandom_range(0, 12))
				pending.push_back(char_t'($urandom_range(1, 255)));
		end else begin
			month = ($urandom_range(0, 6) == 0) ? int'($urandom_range(0, 99))
				: int'($urandom_range(1, 12));
			if ($urandom_range(0, 6) == 0)
				put_num($urandom_range(0, 9999));
			else if (month >= 1 && month <= 12)
				put_num($urandom_range(1, MONTH_DAYS[month - 1] + 1));
			else
				put_num($urandom_range(0, 31));
			put_sep();
			put_num(month);
			put_sep();
			// Years near the floor probe the strict comparison.
			if ($urandom_range(0, 1)) begin
				year = int'(floor_now) + int'($urandom_range(0, 4)) - 2;
				year = (year < 0) ? 0 : (year > 9999) ? 9999 : year;
			end else begin
				year = $urandom_range(0, 9999);
			end
			put_num(year);
			if (kind < 30) begin
				repeat ($urandom_range(1, 3)) begin
					if ($urandom_range(0, 2) == 0)
						pending.push_back(CHAR_SLASH);
					else
						repeat ($urandom_range(1, 10))
							pending.push_back(CHAR_ZERO + char_t'($urandom_range(0, 9)));
				end
			end
			if (kind >= 80) begin
				junk = $urandom_range(0, 1) ? char_t'($urandom_range(8'h3A, 8'hFF))
					: char_t'($urandom_range(8'h01, 8'h2E));
				pos = $urandom_range(0, pending.size());
				pending.insert(pos, junk);
			end
		end
		pending.push_back(CHAR_TERM);
	endfunction

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_char(input char_t c, input bit typed = 1'b0,
			input date_word_t want = '0);
		int gap;
		date_word_t word;
		gap = tx_idle ? int'($urandom_range(0, 12)) : 0;
		if (gap != 0) begin
			char_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		char_bus.valid <= 1'b1;
		char_bus.char_code <= c;
		do @(posedge clk); while (!(char_bus.valid && char_bus.ready));
		if (parse_char(c, word))
			dates_due.push_back(typed ? want : word);
		@(negedge clk);
	endtask

	// Waits until every result word has come and the block has gone quiet.
	task automatic settle();
		char_bus.valid <= 1'b0;
		while (dates_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_floor(input field_t v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_YEAR_FLOOR;
		pwdata <= DATA_W'(v);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		floor_now = v;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic check_floor_reg(input field_t want);
		logic [DATA_W-1:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_YEAR_FLOOR;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		if (got !== DATA_W'(want)) begin
			$error("year_floor: expected %0d, got %0d", want, got);
			mismatches++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	initial begin : stimulus
		int sent;
		arst_n = 1'b0;
		char_bus.valid = 1'b0;
		char_bus.char_code = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		acc = '{default: '0};
		fields_begun = '0;
		run_len = RUN_NONE;
		bad_seen = 1'b0;
		floor_plan = '{14'd0, 14'd9999, 14'd1900, field_t'($urandom_range(0, 9999)), 14'd1,
			field_t'($urandom_range(0, 9999))};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		check_floor_reg(YEAR_FLOOR_RST);

		foreach (dir_rows[r]) begin
			for (int i = 0; i < dir_rows[r].text.len(); i++)
				send_char(char_t'(dir_rows[r].text[i]));
			send_char(CHAR_TERM, dir_rows[r].typed, dir_rows[r].want);
		end

		// Each floor change waits for an idle block, so the sender drains fully here.
		foreach (floor_plan[p]) begin
			settle();
			write_floor(floor_plan[p]);
			check_floor_reg(floor_plan[p]);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) == 0)
					tx_idle = !tx_idle;
				build_date_text();
				foreach (pending[k])
					send_char(pending[k]);
				sent += pending.size();
			end
		end

		settle();
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : result_sink
		int stall;
		date_bus.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0)
				rx_idle = !rx_idle;
			stall = rx_idle ? int'($urandom_range(0, 12)) : 0;
			if (stall != 0) begin
				date_bus.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			date_bus.ready <= 1'b1;
			do @(posedge clk); while (!(date_bus.valid && date_bus.ready));
			@(negedge clk);
		end
	end

	always @(posedge clk) begin : result_check
		date_word_t got;
		date_word_t want;
		if (arst_n && date_bus.valid && date_bus.ready) begin
			got = '{date_bus.date_valid, date_bus.day_field, date_bus.month_field,
				date_bus.year_field};
			if (dates_due.size() == 0) begin
				$error("result word arrived with none expected");
				mismatches++;
			end else begin
				want = dates_due.pop_front();
				if (got.ok !== want.ok) begin
					$error("date_valid: expected %0d, got %0d", want.ok, got.ok);
					mismatches++;
				end
				if (got.day !== want.day) begin
					$error("day_field: expected %0d, got %0d", want.day, got.day);
					mismatches++;
				end
				if (got.month !== want.month) begin
					$error("month_field: expected %0d, got %0d", want.month, got.month);
					mismatches++;
				end
				if (got.year !== want.year) begin
					$error("year_field: expected %0d, got %0d", want.year, got.year);
					mismatches++;
				end
			end
		end
	end

	// Ends a hung run: counts cycles in which no word moves on any port.
	always @(posedge clk) begin
		if (!arst_n || (char_bus.valid && char_bus.ready) || (date_bus.valid && date_bus.ready)
				|| (psel && penable)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+src
src/dsv_pkg.sv
src/dsv_char_if.sv
src/dsv_date_if.sv
src/dsv_apb_regs.sv
src/dsv_parser.sv
src/date_string_validator.sv
tb/date_string_validator_tb.sv
